@@ rtl/cst_pkg.sv @@
package cst_pkg;

    // Separator limits: configured lengths are clamped into this range.
    localparam int MAX_SEPARATOR = 4;
    localparam logic [2:0] SEP_LIMIT = (MAX_SEPARATOR < 4) ? 3'(MAX_SEPARATOR) : 3'd4;

    // Special bytes of the CSV text.
    localparam logic [7:0] BOM_0    = 8'hEF;
    localparam logic [7:0] BOM_1    = 8'hBB;
    localparam logic [7:0] BOM_2    = 8'hBF;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Reset values of the configuration registers.
    localparam logic [31:0] SEP_BYTES_RESET = 32'd44;
    localparam logic [2:0]  SEP_LEN_RESET   = 3'd1;

    // Configuration register indexes.
    localparam logic CFG_SEP_BYTES  = 1'b0;
    localparam logic CFG_SEP_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_CONTENT   = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } token_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        logic [2:0]        count;
        token_t [3:0]      tok;
    } batch_t;

    // One input beat as held in the input register.
    typedef struct packed {
        logic       end_of_text;
        logic [7:0] text_byte;
    } item_t;

    typedef struct packed {
        logic inside_quotes;
        logic field_was_quoted;
        logic field_is_empty;
        logic row_has_content;
        logic quote_pending;
        logic cr_seen;
        logic at_doc_start;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        inside_quotes:    1'b0,
        field_was_quoted: 1'b0,
        field_is_empty:   1'b1,
        row_has_content:  1'b0,
        quote_pending:    1'b0,
        cr_seen:          1'b0,
        at_doc_start:     1'b1
    };

    typedef struct packed {
        logic         stop;
        logic         emit;
        token_t       tok;
        logic [2:0]   pop;
        parse_state_t st;
    } step_t;

    // One pass of the tokenizer over the head of the working window.
    // The window holds fill valid bytes, the head in entry 0.
    function automatic step_t parse_step(
        parse_state_t     st,
        logic [3:0][7:0]  w,
        logic [2:0]       fill,
        logic             last_pass,
        logic [31:0]      sep,
        logic [2:0]       len
    );
        step_t      r;
        logic       m0;
        logic       m1;
        logic       m2;
        logic       partial;
        logic       done;
        logic       match;
        logic [7:0] h;

        r.stop     = 1'b0;
        r.emit     = 1'b0;
        r.tok.kind = KIND_CONTENT;
        r.tok.data = 8'd0;
        r.pop      = 3'd0;
        r.st       = st;
        done       = 1'b0;
        match      = 1'b0;
        h          = w[0];

        // Byte-order mark prefix tracking.
        m0      = (fill >= 3'd1) && (w[0] == BOM_0);
        m1      = m0 && (fill >= 3'd2) && (w[1] == BOM_1);
        m2      = m1 && (fill >= 3'd3) && (w[2] == BOM_2);
        partial = ((fill == 3'd1 && m0) || (fill == 3'd2 && m1)) && !last_pass;

        if (fill == 3'd0)
        begin
            r.stop = 1'b1;
            done   = 1'b1;
        end

        if (!done && r.st.at_doc_start)
        begin
            if (partial)
            begin
                r.stop = 1'b1;
                done   = 1'b1;
            end
            else
            begin
                r.st.at_doc_start = 1'b0;
                if (m2)
                begin
                    r.pop = 3'd3;
                    done  = 1'b1;
                end
            end
        end

        // A line feed right after a row ended on CR is dropped.
        if (!done && r.st.cr_seen)
        begin
            r.st.cr_seen = 1'b0;
            if (h == CH_LF)
            begin
                r.pop = 3'd1;
                done  = 1'b1;
            end
        end

        // Quoted field body.
        if (!done && r.st.inside_quotes)
        begin
            if (r.st.quote_pending)
            begin
                r.st.quote_pending = 1'b0;
                if (h == CH_QUOTE)
                begin
                    r.emit              = 1'b1;
                    r.tok.data          = CH_QUOTE;
                    r.st.field_is_empty = 1'b0;
                    r.pop               = 3'd1;
                    done                = 1'b1;
                end
                else
                begin
                    r.st.inside_quotes = 1'b0;
                end
            end
            else if (h == CH_QUOTE)
            begin
                r.st.quote_pending = 1'b1;
                r.pop              = 3'd1;
                done               = 1'b1;
            end
            else
            begin
                r.emit              = 1'b1;
                r.tok.data          = h;
                r.st.field_is_empty = 1'b0;
                r.pop               = 3'd1;
                done                = 1'b1;
            end
        end

        // Opening quote at the start of an unquoted field.
        if (!done && h == CH_QUOTE && r.st.field_is_empty && !r.st.field_was_quoted)
        begin
            r.st.inside_quotes    = 1'b1;
            r.st.field_was_quoted = 1'b1;
            r.st.row_has_content  = 1'b1;
            r.pop                 = 3'd1;
            done                  = 1'b1;
        end

        // Wait for enough bytes to compare against the separator.
        if (!done && fill < len && !last_pass)
        begin
            r.stop = 1'b1;
            done   = 1'b1;
        end

        if (!done)
        begin
            match = (fill >= len);
            for (int k = 0; k < 4; k++)
            begin
                if (3'(k) < len && w[k] != sep[8*k +: 8])
                    match = 1'b0;
            end

            if (match)
            begin
                r.emit                = 1'b1;
                r.tok.kind            = KIND_FIELD_END;
                r.st.field_is_empty   = 1'b1;
                r.st.field_was_quoted = 1'b0;
                r.st.row_has_content  = 1'b1;
                r.pop                 = len;
            end
            else if (h == CH_CR || h == CH_LF)
            begin
                r.emit                = 1'b1;
                r.tok.kind            = KIND_ROW_END;
                r.st.field_is_empty   = 1'b1;
                r.st.field_was_quoted = 1'b0;
                r.st.row_has_content  = 1'b0;
                r.st.cr_seen          = (h == CH_CR);
                r.pop                 = 3'd1;
            end
            else
            begin
                r.emit               = 1'b1;
                r.tok.data           = h;
                r.st.field_is_empty  = 1'b0;
                r.st.row_has_content = 1'b1;
                r.pop                = 3'd1;
            end
        end

        return r;
    endfunction

endpackage

@@ rtl/csv_stream_tokenizer.sv @@
// CSV tokenizer: one byte of text enters per beat on s_axis (tlast marks end of
// document and its data byte is ignored), and field content bytes, end-of-field
// and end-of-row tokens leave one per beat on m_axis, with tlast on the final
// token caused by each input beat. A byte passes through an input register and
// the parsing logic into a four-entry result buffer, from which its tokens are
// presented on m_axis; while the result buffer is not free, the byte waits.
// Each input beat yields zero to four tokens; the block takes one byte per cycle
// as long as each byte yields at most one token and m_axis_tready stays high; a
// byte that yields several tokens holds the input while the result buffer drains
// them, one token per cycle while m_axis_tready is high. A partial byte-order
// mark may hold up to two bytes and a separator prefix up to three bytes before
// their tokens come out; a quote inside a quoted field is decided by the byte
// that follows it. Write separator_bytes (index 0) and separator_length
// (index 1) only while the block is idle.
module csv_stream_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] token_kind, [9:2] content_byte
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import cst_pkg::*;

    logic [31:0] sep_bytes_reg;
    logic [2:0]  sep_len_reg;
    logic [2:0]  sep_len_eff;
    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        buf_free;
    logic        fire;
    batch_t      batch;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_bytes_reg <= SEP_BYTES_RESET;
            sep_len_reg   <= SEP_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEP_BYTES:  sep_bytes_reg <= cfg_data;
                CFG_SEP_LENGTH: sep_len_reg   <= cfg_data[2:0];
                default:        sep_len_reg   <= sep_len_reg;
            endcase
        end
    end

    // Zero length behaves as one; long separators are clamped.
    always_comb
    begin
        sep_len_eff = (sep_len_reg == 3'd0) ? 3'd1 : sep_len_reg;
        if (sep_len_eff > SEP_LIMIT)
            sep_len_eff = SEP_LIMIT;
    end

    // Input register: the held beat moves on when the result buffer is free.
    assign fire          = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.text_byte   <= s_axis_tdata;
            in_item_reg.end_of_text <= s_axis_tlast;
        end
    end

    cst_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .sep_bytes (sep_bytes_reg),
        .sep_len   (sep_len_eff),
        .batch     (batch)
    );

    cst_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .batch         (batch),
        .free          (buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/cst_parser.sv @@
module cst_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  cst_pkg::item_t  item,
    input  logic [31:0]     sep_bytes,
    input  logic [2:0]      sep_len,
    output cst_pkg::batch_t batch
);
    import cst_pkg::*;

    parse_state_t    state_reg;
    parse_state_t    state_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic [2:0][7:0] win_reg;
    logic [2:0][7:0] win_next;

    parse_state_t    st;
    logic [3:0][7:0] w;
    logic [2:0]      fill;
    logic            stopped;
    step_t           s;

    // Run up to four passes over the window plus the new byte; each pass
    // consumes at least one byte or stops.
    always_comb
    begin
        st          = state_reg;
        w[2:0]      = win_reg;
        w[3]        = item.text_byte;
        if (!item.end_of_text)
            w[fill_reg] = item.text_byte;
        fill        = {1'b0, fill_reg} + {2'd0, !item.end_of_text};
        stopped     = 1'b0;
        batch.count = 3'd0;
        batch.tok   = '0;
        s           = '0;

        for (int i = 0; i < 4; i++)
        begin
            if (!stopped)
            begin
                s  = parse_step(st, w, fill, item.end_of_text, sep_bytes, sep_len);
                st = s.st;
                if (s.emit && batch.count < 3'd4)
                begin
                    batch.tok[batch.count[1:0]] = s.tok;
                    batch.count                 = batch.count + 3'd1;
                end
                w       = w >> {s.pop, 3'b000};
                fill    = fill - s.pop;
                stopped = s.stop;
            end
        end

        // End of text closes a row that has content, then everything resets.
        if (item.end_of_text)
        begin
            if (st.row_has_content && batch.count < 3'd4)
            begin
                batch.tok[batch.count[1:0]].kind = KIND_ROW_END;
                batch.tok[batch.count[1:0]].data = 8'd0;
                batch.count                      = batch.count + 3'd1;
            end
            state_next = STATE_RESET;
            fill_next  = 2'd0;
        end
        else
        begin
            state_next = st;
            fill_next  = fill[1:0];
        end
        win_next = w[2:0];
    end

    // Parser state advances once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            fill_reg  <= 2'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // Lookahead bytes; only entries below the fill count are ever used.
    always_ff @(posedge clk)
    begin
        if (fire)
            win_reg <= win_next;
    end

endmodule

@@ rtl/cst_out_buf.sv @@
module cst_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  cst_pkg::batch_t batch,
    output logic            free,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // [1:0] token_kind, [9:2] content_byte
    output logic            m_axis_tlast    // last_of_run
);
    import cst_pkg::*;

    token_t [3:0] tok_reg;
    logic [2:0]   cnt_reg;
    logic [1:0]   rd_reg;
    token_t       head;

    assign head          = tok_reg[rd_reg];
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = {6'd0, head.data, head.kind};
    assign m_axis_tlast  = (cnt_reg == 3'd1);

    // The buffer takes a new batch once its last beat leaves.
    assign free = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_axis_tready);

    // Remaining-beat count and read pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.count;
            rd_reg  <= 2'd0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
            tok_reg <= batch.tok;
    end

endmodule
